@@ hdl/tcm_pkg.sv @@
`default_nettype none

package tcm_pkg;

   // Default sizing of the codeword table
   localparam int TCM_MAX_CODES  = 4096;
   localparam int TCM_CODE_WIDTH = 63;

   // Fixed field widths
   localparam int WORD_W     = 63;
   localparam int ID_W       = 12;
   localparam int COUNT_W    = 13;
   localparam int NB_W       = 6;
   localparam int MH_W       = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int NUM_ROT    = 4;

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HAMMING = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CODES   = 2'd2;

   // Command codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROT,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Control that travels with a table read beat
   typedef struct packed {
      logic            clear;
      logic            valid;
      logic [ID_W-1:0] id;
   } scan_ctl_type;

   // Status and chosen match from the compare unit
   typedef struct packed {
      logic            busy;
      logic            found;
      logic [ID_W-1:0] id;
      logic [1:0]      errs;
      logic [1:0]      rot;
   } match_status_type;

endpackage

`default_nettype wire

@@ hdl/tcm_table.sv @@
`default_nettype none

module tcm_table
   import tcm_pkg::*;
#(
   parameter int DEPTH  = TCM_MAX_CODES,
   parameter int WIDTH  = TCM_CODE_WIDTH,
   parameter int ADDR_W = 12
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/tcm_match.sv @@
`default_nettype none

module tcm_match
   import tcm_pkg::*;
#(
   parameter int CODE_WIDTH = TCM_CODE_WIDTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire scan_ctl_type                      ctl,
   input  wire logic [CODE_WIDTH-1:0]             rd_data,
   input  wire logic [NUM_ROT-1:0][CODE_WIDTH-1:0] words,
   input  wire logic [CODE_WIDTH-1:0]             payload_mask,
   input  wire logic [1:0]                        limit,
   output      match_status_type                  status,
   output      logic [CODE_WIDTH-1:0]             best_code
);

   // Bit count of a word, saturating at three
   function automatic logic [1:0] ones_sat(input logic [CODE_WIDTH-1:0] x);
      logic [CODE_WIDTH-1:0] y;
      logic [CODE_WIDTH-1:0] z;
      logic [1:0]            c;
      y = x & (x - CODE_WIDTH'(1));
      z = y & (y - CODE_WIDTH'(1));
      if (x == '0)      c = 2'd0;
      else if (y == '0) c = 2'd1;
      else if (z == '0) c = 2'd2;
      else              c = 2'd3;
      return c;
   endfunction

   // Compare stage registers
   logic                  b_valid_ff, b_valid_in;
   logic [ID_W-1:0]       b_id_ff, b_id_in;
   logic [CODE_WIDTH-1:0] b_code_ff, b_code_in;
   logic [NUM_ROT-1:0]    b_hit_ff, b_hit_in;
   logic [NUM_ROT-1:0][1:0] b_dist_ff, b_dist_in;

   // First match per rotation
   logic [NUM_ROT-1:0]                 found_ff, found_in;
   logic [NUM_ROT-1:0][ID_W-1:0]       id_ff, id_in;
   logic [NUM_ROT-1:0][CODE_WIDTH-1:0] code_ff, code_in;
   logic [NUM_ROT-1:0][1:0]            dist_ff, dist_in;

   // Distance of the read codeword to every rotated word
   always_comb begin
      logic [CODE_WIDTH-1:0] diff;
      logic [1:0]            cnt;
      b_valid_in = ctl.valid;
      b_id_in    = ctl.id;
      b_code_in  = rd_data;
      for (int r = 0; r < NUM_ROT; r++) begin
         diff         = words[r] ^ rd_data;
         cnt          = ones_sat(diff);
         b_dist_in[r] = cnt;
         b_hit_in[r]  = ((diff & ~payload_mask) == '0) && (cnt <= limit);
      end
   end

   // Keep the lowest id that hits in each rotation
   always_comb begin
      found_in = found_ff;
      id_in    = id_ff;
      code_in  = code_ff;
      dist_in  = dist_ff;
      if (ctl.clear) begin
         found_in = '0;
      end else if (b_valid_ff) begin
         for (int r = 0; r < NUM_ROT; r++) begin
            if (b_hit_ff[r] && !found_ff[r]) begin
               found_in[r] = 1'b1;
               id_in[r]    = b_id_ff;
               code_in[r]  = b_code_ff;
               dist_in[r]  = b_dist_ff[r];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         found_ff   <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         found_ff   <= found_in;
      end
      b_id_ff   <= b_id_in;
      b_code_ff <= b_code_in;
      b_hit_ff  <= b_hit_in;
      b_dist_ff <= b_dist_in;
      id_ff     <= id_in;
      code_ff   <= code_in;
      dist_ff   <= dist_in;
   end

   // Lowest rotation with a match wins; found, id, errs, rot and code are zero when none matched
   always_comb begin
      status.busy  = b_valid_ff;
      status.found = 1'b0;
      status.id    = '0;
      status.errs  = '0;
      status.rot   = '0;
      best_code    = '0;
      for (int r = NUM_ROT - 1; r >= 0; r--) begin
         if (found_ff[r]) begin
            status.found = 1'b1;
            status.id    = id_ff[r];
            status.errs  = dist_ff[r];
            status.rot   = 2'(r);
            best_code    = code_ff[r];
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/tag_code_match_with_rotation_unit.sv @@
`default_nettype none
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  command, entry_index, code_word
// rsp      out        rsp_valid/rsp_stall  found, tag_id, decoded_code, bit_errors, rotation
// csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// A load is answered in the cycle after its beat; it waits while an
// earlier answer is held and not taken.
// A decode first builds the quarter turns of its word, then scans count =
// min(num_codes, MAX_CODES) codewords: the single table read port delivers
// one codeword a cycle, each checked against all four rotations. It then
// drains the compare unit and loads the answer. Reset is synchronous; the
// table itself is not cleared.
// rsp_stall holds the answer register; a new decode can start meanwhile.

module tag_code_match_with_rotation_unit
   import tcm_pkg::*;
#(
   parameter int MAX_CODES  = TCM_MAX_CODES,
   parameter int CODE_WIDTH = TCM_CODE_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic                  req_command,
   input  wire logic [ID_W-1:0]       req_entry_index,
   input  wire logic [WORD_W-1:0]     req_code_word,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic                  rsp_found,
   output      logic [ID_W-1:0]       rsp_tag_id,
   output      logic [WORD_W-1:0]     rsp_decoded_code,
   output      logic [1:0]            rsp_bit_errors,
   output      logic [1:0]            rsp_rotation,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int ADDR_W = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;

   // One quarter turn of an n-bit word, centre bit fixed when n mod 4 is 1
   function automatic logic [CODE_WIDTH-1:0] quarter_turn(input logic [CODE_WIDTH-1:0] w,
                                                          input logic [NB_W-1:0] n);
      logic            l;
      logic [NB_W-1:0] p;
      logic [4:0]      sh1;
      logic [7:0]      p3;
      logic [5:0]      sh2;
      logic [63:0]     w64;
      logic [63:0]     t;
      logic [63:0]     m;
      l   = (n[1:0] == 2'b01);
      p   = l ? (n - NB_W'(1)) : n;
      sh1 = 5'(p >> 2) + 5'(l);
      p3  = 8'(p) * 8'd3;
      sh2 = 6'(p3 >> 2) + 6'(l);
      w64 = 64'(w);
      t   = ((w64 >> l) << sh1) | ((w64 >> sh2) << l) | (w64 & 64'(l));
      for (int i = 0; i < 64; i++) begin
         m[i] = (7'(i) < 7'(n));
      end
      return CODE_WIDTH'(t & m);
   endfunction

   // Configuration registers
   logic [NB_W-1:0]    num_bits_ff, num_bits_in;
   logic [MH_W-1:0]    max_hamming_ff, max_hamming_in;
   logic [COUNT_W-1:0] num_codes_ff, num_codes_in;

   // Control
   state_type          state_ff, state_in;
   logic [1:0]         rot_cnt_ff, rot_cnt_in;
   logic [COUNT_W-1:0] scan_id_ff, scan_id_in;
   scan_ctl_type       rd_ctl_ff, rd_ctl_in;
   logic [NUM_ROT-1:0][CODE_WIDTH-1:0] rot_word_ff, rot_word_in;
   logic [CODE_WIDTH-1:0] rot_cur_ff, rot_cur_in;

   // Answer register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [ID_W-1:0]     rsp_tag_id_ff, rsp_tag_id_in;
   logic [WORD_W-1:0]   rsp_code_ff, rsp_code_in;
   logic [1:0]          rsp_bit_errors_ff, rsp_bit_errors_in;
   logic [1:0]          rsp_rotation_ff, rsp_rotation_in;

   logic                  accept;
   logic                  rsp_free;
   logic                  load_rsp;
   logic                  fin_rsp;
   logic                  rd_en;
   logic                  wr_en;
   logic [COUNT_W-1:0]    count;
   logic [1:0]            limit;
   logic [CODE_WIDTH-1:0] payload_mask;
   logic [CODE_WIDTH-1:0] rd_data;
   logic [CODE_WIDTH-1:0] in_word;
   logic [CODE_WIDTH-1:0] turned;
   match_status_type      status;
   logic [CODE_WIDTH-1:0] best_code;

   // Derived settings
   assign limit = (max_hamming_ff == 2'd3) ? 2'd2 : max_hamming_ff;
   assign count = (32'(num_codes_ff) > MAX_CODES) ? COUNT_W'(MAX_CODES) : num_codes_ff;
   always_comb begin
      for (int i = 0; i < CODE_WIDTH; i++) begin
         payload_mask[i] = (7'(i) < 7'(num_bits_ff));
      end
   end

   assign in_word  = CODE_WIDTH'(req_code_word);
   assign turned   = quarter_turn(rot_cur_ff, num_bits_ff);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;
   assign wr_en    = accept && (req_command == CMD_LOAD) && (32'(req_entry_index) < MAX_CODES);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_DECODE)) state_in = ST_ROT;
         end
         ST_ROT: begin
            if (rot_cnt_ff == 2'd3) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_id_ff >= count) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!rd_ctl_ff.valid && !status.busy) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      load_rsp  = 1'b0;
      fin_rsp   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = (req_command == CMD_LOAD) && !rsp_free;
            load_rsp  = req_valid && !req_stall && (req_command == CMD_LOAD);
         end
         ST_ROT: begin
         end
         ST_SCAN: begin
            rd_en = (scan_id_ff < count);
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            fin_rsp = rsp_free;
         end
         default: begin
         end
      endcase
   end

   // Rotation and scan bookkeeping
   always_comb begin
      rot_cnt_in  = rot_cnt_ff;
      rot_cur_in  = rot_cur_ff;
      rot_word_in = rot_word_ff;
      scan_id_in  = scan_id_ff;
      rd_ctl_in.clear = accept && (req_command == CMD_DECODE);
      rd_ctl_in.valid = rd_en;
      rd_ctl_in.id    = scan_id_ff[ID_W-1:0];
      if (accept && (req_command == CMD_DECODE)) begin
         rot_word_in[0] = in_word;
         rot_cur_in     = in_word;
         rot_cnt_in     = 2'd1;
         scan_id_in     = '0;
      end
      if (state_ff == ST_ROT) begin
         rot_word_in[rot_cnt_ff] = turned;
         rot_cur_in              = turned;
         rot_cnt_in              = rot_cnt_ff + 2'd1;
      end
      if (rd_en) begin
         scan_id_in = scan_id_ff + COUNT_W'(1);
      end
   end

   // Configuration writes
   assign csr_ready = 1'b1;
   always_comb begin
      num_bits_in    = num_bits_ff;
      max_hamming_in = max_hamming_ff;
      num_codes_in   = num_codes_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NUM_BITS:    num_bits_in    = csr_data[NB_W-1:0];
            CSR_MAX_HAMMING: max_hamming_in = csr_data[MH_W-1:0];
            CSR_NUM_CODES:   num_codes_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Answer register: a load gets all zero fields, a finished decode the chosen match
   always_comb begin
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_found_in      = rsp_found_ff;
      rsp_tag_id_in     = rsp_tag_id_ff;
      rsp_code_in       = rsp_code_ff;
      rsp_bit_errors_in = rsp_bit_errors_ff;
      rsp_rotation_in   = rsp_rotation_ff;
      if (load_rsp) begin
         rsp_valid_in      = 1'b1;
         rsp_found_in      = 1'b0;
         rsp_tag_id_in     = '0;
         rsp_code_in       = '0;
         rsp_bit_errors_in = '0;
         rsp_rotation_in   = '0;
      end else if (fin_rsp) begin
         rsp_valid_in      = 1'b1;
         rsp_found_in      = status.found;
         rsp_tag_id_in     = status.id;
         rsp_code_in       = WORD_W'(best_code);
         rsp_bit_errors_in = status.errs;
         rsp_rotation_in   = status.rot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_bits_ff    <= NB_W'(36);
         max_hamming_ff <= MH_W'(2);
         num_codes_ff   <= '0;
         state_ff       <= ST_IDLE;
         rot_cnt_ff     <= '0;
         scan_id_ff     <= '0;
         rd_ctl_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         num_bits_ff    <= num_bits_in;
         max_hamming_ff <= max_hamming_in;
         num_codes_ff   <= num_codes_in;
         state_ff       <= state_in;
         rot_cnt_ff     <= rot_cnt_in;
         scan_id_ff     <= scan_id_in;
         rd_ctl_ff      <= rd_ctl_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rot_word_ff       <= rot_word_in;
      rot_cur_ff        <= rot_cur_in;
      rsp_found_ff      <= rsp_found_in;
      rsp_tag_id_ff     <= rsp_tag_id_in;
      rsp_code_ff       <= rsp_code_in;
      rsp_bit_errors_ff <= rsp_bit_errors_in;
      rsp_rotation_ff   <= rsp_rotation_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_tag_id       = rsp_tag_id_ff;
   assign rsp_decoded_code = rsp_code_ff;
   assign rsp_bit_errors   = rsp_bit_errors_ff;
   assign rsp_rotation     = rsp_rotation_ff;

   tcm_table #(
      .DEPTH  (MAX_CODES),
      .WIDTH  (CODE_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_entry_index)),
      .wr_data (in_word),
      .rd_en   (rd_en),
      .rd_addr (ADDR_W'(scan_id_ff)),
      .rd_data (rd_data)
   );

   tcm_match #(
      .CODE_WIDTH (CODE_WIDTH)
   ) u_match (
      .clock        (clock),
      .reset        (reset),
      .ctl          (rd_ctl_ff),
      .rd_data      (rd_data),
      .words        (rot_word_ff),
      .payload_mask (payload_mask),
      .limit        (limit),
      .status       (status),
      .best_code    (best_code)
   );

`ifndef SYNTH
   // A load beat is answered on the next cycle with found low
   a_load_answer: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == CMD_LOAD)) |=> (rsp_valid_ff && !rsp_found_ff))
      else $error("load beat not answered");

   // A reported match never exceeds the error limit
   a_dist_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_bit_errors_ff <= limit))
      else $error("match distance above limit");

   // The scan never runs past the codewords in use
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_id_ff <= count))
      else $error("scan index past table count");
`endif

endmodule

`default_nettype wire
